// ===== design/wrjs_pkg.sv =====
// Package: shared types and constants of the weighted-ratio job sorter.
package wrjs_pkg;

    localparam int MAX_JOBS_DEF = 64;
    localparam int DAYS_W       = 16;
    localparam int FINE_W       = 16;
    localparam int NUM_W        = 7;

    typedef struct packed {
        logic [DAYS_W-1:0] job_days;
        logic [FINE_W-1:0] job_fine;
        logic              set_end;
    } job_req_t;

    typedef struct packed {
        logic [NUM_W-1:0] job_number;
        logic             final_job;
        logic             jobs_dropped;
    } job_res_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_CUR,
        ST_RD_PREV,
        ST_RD_DATA,
        ST_CMP,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT
    } sort_state_t;

endpackage

// ===== design/wrjs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
module wrjs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/weighted_ratio_job_sorter.sv =====
// Top level: weighted-ratio job sorter (Smith rule) with memory-based insertion sort.
//
//  channel | direction | handshake        | payload
//  request | in        | start / busy     | req  (job_req_t)
//  result  | out       | res_valid strobe | res  (job_res_t)
//
// Loading accepts one job per cycle; busy stays low while jobs are stored.
// After the job carrying set_end, busy rises while an insertion sort runs over
// an index memory: job 0 goes straight to the head; every later job is fetched,
// then the index at j-1, that job's data and a compare follow. Each further shift
// step repeats index read, data read and compare; a job reaching the head is
// placed in a step of its own. A step spots the end, then each result is read
// and emitted. Reset clears the state, job count, drop flag and i/j counters.
// Results appear for one cycle each; the receiver cannot stall them.
module weighted_ratio_job_sorter
    import wrjs_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  wrjs_pkg::job_req_t req,
    output logic               res_valid,
    output wrjs_pkg::job_res_t res
);
    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    sort_state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;   // jobs stored
    logic          drop_reg, drop_next;
    logic [CW-1:0] i_reg, i_next;           // job being inserted
    logic [CW-1:0] j_reg, j_next;           // hole position
    logic [AW-1:0] cur_reg, cur_next;       // index of job being inserted
    logic [DAYS_W-1:0] cd_reg, cd_next;     // its days and fine
    logic [FINE_W-1:0] cf_reg, cf_next;
    logic [AW-1:0] prev_reg, prev_next;     // index at j-1

    // Job stores: data memories addressed by job index.
    logic              st_we;
    logic [AW-1:0]     st_waddr, st_raddr;
    logic [DAYS_W-1:0] st_wdays, days_rd;
    logic [FINE_W-1:0] fine_rd;
    // Order memory: sorted job indices.
    logic              ord_we;
    logic [AW-1:0]     ord_waddr, ord_raddr, ord_rd;
    logic [AW-1:0]     ord_wdata;

    wrjs_ram #(.WIDTH(DAYS_W), .DEPTH(MAX_JOBS)) u_days (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdays),
        .raddr(st_raddr), .rdata(days_rd));
    wrjs_ram #(.WIDTH(FINE_W), .DEPTH(MAX_JOBS)) u_fine (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(req.job_fine),
        .raddr(st_raddr), .rdata(fine_rd));
    wrjs_ram #(.WIDTH(AW), .DEPTH(MAX_JOBS)) u_order (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rd));

    logic accept;
    logic room;
    logic [31:0] lhs, rhs;
    logic cur_first;

    assign accept   = start && !busy;
    assign room     = (count_reg < CW'(MAX_JOBS));
    assign st_wdays = (req.job_days == '0) ? DAYS_W'(1) : req.job_days;
    assign st_waddr = count_reg[AW-1:0];
    assign st_we    = accept && room;

    // cross products: cur vs job at j-1 (its data on the store outputs in ST_CMP)
    assign lhs = 32'(cf_reg) * 32'(days_rd);
    assign rhs = 32'(fine_rd) * 32'(cd_reg);
    assign cur_first = (lhs > rhs) || ((lhs == rhs) && (cur_reg < prev_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && req.set_end)
                begin
                    state_next = ST_RD_CUR;
                end
            end
            ST_RD_CUR:
            begin
                if (i_reg == count_reg)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (i_reg == '0)
                begin
                    state_next = ST_RD_CUR;
                end
                else
                begin
                    state_next = ST_RD_PREV;
                end
            end
            ST_RD_PREV: state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = ST_CMP;
            ST_CMP:
            begin
                state_next = ST_RD_CUR;
                if (cur_first)
                begin
                    state_next = (j_reg > CW'(1)) ? ST_RD_PREV : ST_PLACE;
                end
            end
            ST_PLACE: state_next = ST_RD_CUR;
            ST_EMIT_RD: state_next = ST_EMIT;
            ST_EMIT:
            begin
                state_next = (i_reg == count_reg - CW'(1)) ? ST_LOAD : ST_EMIT_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cur_next   = cur_reg;
        cd_next    = cd_reg;
        cf_next    = cf_reg;
        prev_next  = prev_reg;
        st_raddr   = cur_reg;
        ord_raddr  = '0;
        ord_we     = 1'b0;
        ord_waddr  = j_reg[AW-1:0];
        ord_wdata  = cur_reg;
        res_valid  = 1'b0;
        res        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (req.set_end)
                    begin
                        i_next = '0;
                    end
                end
            end
            ST_RD_CUR:
            begin
                // fetch job i's data; the first job goes straight to the head
                if (i_reg != count_reg)
                begin
                    st_raddr = i_reg[AW-1:0];
                    cur_next = i_reg[AW-1:0];
                    j_next   = i_reg;
                    if (i_reg == '0)
                    begin
                        ord_we    = 1'b1;
                        ord_waddr = '0;
                        ord_wdata = '0;
                        i_next    = i_reg + CW'(1);
                    end
                end
                else
                begin
                    i_next = '0;
                end
            end
            ST_RD_PREV:
            begin
                // first pass after ST_RD_CUR: cur's data on the store outputs
                if (j_reg == i_reg)
                begin
                    cd_next = days_rd;
                    cf_next = fine_rd;
                end
                ord_raddr = AW'(j_reg - CW'(1));
            end
            ST_RD_DATA:
            begin
                // index at j-1 is out; fetch that job's data
                prev_next = ord_rd;
                st_raddr  = ord_rd;
            end
            ST_CMP:
            begin
                ord_we = 1'b1;
                if (cur_first)
                begin
                    // shift the neighbour up one place
                    ord_waddr = j_reg[AW-1:0];
                    ord_wdata = prev_reg;
                    j_next    = j_reg - CW'(1);
                end
                else
                begin
                    ord_waddr = j_reg[AW-1:0];
                    ord_wdata = cur_reg;
                    i_next    = i_reg + CW'(1);
                end
            end
            ST_PLACE:
            begin
                ord_we    = 1'b1;
                ord_waddr = j_reg[AW-1:0];
                ord_wdata = cur_reg;
                i_next    = i_reg + CW'(1);
            end
            ST_EMIT_RD:
            begin
                ord_raddr = i_reg[AW-1:0];
            end
            ST_EMIT:
            begin
                res_valid        = 1'b1;
                res.job_number   = NUM_W'(ord_rd) + NUM_W'(1);
                res.final_job    = (i_reg == count_reg - CW'(1));
                res.jobs_dropped = drop_reg;
                i_next           = i_reg + CW'(1);
                if (i_reg == count_reg - CW'(1))
                begin
                    count_next = '0;
                    drop_next  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != ST_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        cd_reg   <= cd_next;
        cf_reg   <= cf_next;
        prev_reg <= prev_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_JOBS)) else $error("job count beyond capacity");
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.final_job |=> count_reg == '0 && !drop_reg)
        else $error("set not cleared after final result");
    a_no_result_loading: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !res_valid) else $error("result while loading");
`endif
endmodule

// ===== tb/weighted_ratio_job_sorter_tb.sv =====
// Testbench for the weighted-ratio job sorter: Smith-rule ordering checked against a local model.
`timescale 1ns / 100ps

module weighted_ratio_job_sorter_tb;
    import wrjs_pkg::*;

    localparam int CAP = MAX_JOBS_DEF;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    job_req_t req = '0;
    logic     res_valid;
    job_res_t res;

    int unsigned errors = 0;
    bit          calm = 1'b0;      // no idling in the closing part

    // local copy of the job store
    logic [DAYS_W-1:0] days_mem [CAP];
    logic [FINE_W-1:0] fine_mem [CAP];
    int unsigned       stored_jobs = 0;
    bit                dropped = 1'b0;

    job_res_t order_q [$];         // expected results (job numbers and flags) still to be emitted

    always #4 clk = ~clk;

    weighted_ratio_job_sorter DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .res_valid(res_valid), .res(res)
    );

    // p goes ahead of q: larger fine/days ratio, ties by arrival
    function automatic bit ranks_ahead(int p, int q);
        logic [31:0] lhs;
        logic [31:0] rhs;
        lhs = 32'(fine_mem[p]) * 32'(days_mem[q]);
        rhs = 32'(fine_mem[q]) * 32'(days_mem[p]);
        if (lhs != rhs)
            return lhs > rhs;
        return p < q;
    endfunction

    // store one accepted job and, at set end, queue the expected ordering
    task automatic schedule_job(job_req_t j);
        int       idx [CAP];
        int       n;
        int       cur;
        int       k;
        job_res_t r;
        if (stored_jobs < CAP)
        begin
            days_mem[stored_jobs] = (j.job_days == 0) ? 16'd1 : j.job_days;
            fine_mem[stored_jobs] = j.job_fine;
            stored_jobs++;
        end
        else
            dropped = 1'b1;
        if (!j.set_end)
            return;
        n = stored_jobs;
        for (int i = 0; i < n; i++)
        begin
            cur = i;
            k = i;
            while (k > 0 && ranks_ahead(cur, idx[k-1]))
            begin
                idx[k] = idx[k-1];
                k--;
            end
            idx[k] = cur;
        end
        for (int i = 0; i < n; i++)
        begin
            r.job_number   = NUM_W'(idx[i] + 1);
            r.final_job    = (i == n - 1);
            r.jobs_dropped = dropped;
            order_q.push_back(r);
        end
        stored_jobs = 0;
        dropped = 1'b0;
    endtask

    // checker: every strobe is matched against the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n && res_valid)
        begin
            if (order_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, res);
                errors++;
            end
            else
            begin
                if (res !== order_q[0])
                begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, order_q[0], res);
                    errors++;
                end
                void'(order_q.pop_front());
            end
        end
    end

    // send one request; held until accepted at a rising edge with busy low
    task automatic send_job(logic [15:0] d, logic [15:0] f, bit last);
        job_req_t j;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        j.job_days = d;
        j.job_fine = f;
        j.set_end  = last;
        start <= 1'b1;
        req   <= j;
        do
            @(posedge clk);
        while (busy);
        schedule_job(j);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (order_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [15:0] rnd16();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    // extremes of the fields, zero days, ties and single-job sets
    task automatic test_directed();
        send_job(16'd1, 16'd0, 1'b1);
        send_job(16'hFFFF, 16'hFFFF, 1'b0);
        send_job(16'd1, 16'hFFFF, 1'b0);
        send_job(16'd0, 16'd5, 1'b0);           // zero days counts as one
        send_job(16'd1, 16'd5, 1'b0);           // ties with the previous one
        send_job(16'd2, 16'd10, 1'b0);          // same ratio again
        send_job(16'hFFFF, 16'd0, 1'b0);
        send_job(16'h5555, 16'hAAAA, 1'b0);
        send_job(16'hAAAA, 16'h5555, 1'b1);
        for (int i = 0; i < 4; i++)
            send_job(16'd3, 16'd7, i == 3);     // all equal: arrival order
        wait_drained();
    endtask

    // fills the store, or overfills it so the drop flag is set on every result
    task automatic test_overflow(int total);
        for (int i = 0; i < total; i++)
            send_job(rnd16(), rnd16(), i == total - 1);
        wait_drained();
    endtask

    task automatic test_random_sets(int items);
        int left;
        int n;
        left = items;
        while (left > 0)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, CAP) : $urandom_range(1, 8);
            if (n > left)
                n = left;
            for (int i = 0; i < n; i++)
                send_job(rnd16(), rnd16(), i == n - 1);
            left -= n;
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_overflow(CAP);                     // exactly full, no drop
        test_overflow(CAP + 3);                 // set end itself is dropped
        test_random_sets(140);
        calm = 1'b1;
        test_random_sets(50);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
